>>> sv/imd_pkg.sv
// Shared types, constants and tables for the IMU midpoint dead-reckoning core.
// Used by imd_mul, imd_rootdiv and imu_midpoint_dead_reckoning_core.
`default_nettype none

package imd_pkg;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [31:0]        stamp;
	} imd_sample_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
	} imd_result_t;

	localparam int MUL_W  = 36;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 56;

	localparam logic [1:0] REG_GRAV_X = 2'd0;
	localparam logic [1:0] REG_GRAV_Y = 2'd1;
	localparam logic [1:0] REG_GRAV_Z = 2'd2;

	localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;
	localparam logic signed [ACC_W-1:0] P_LIM = 56'sh1_FFFF_FFFF;
	localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;

	typedef enum logic {RD_ROOT, RD_DIV} rd_op_t;

	typedef struct packed {
		logic   start;
		rd_op_t op;
	} rd_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} rd_rsp_t;

	// quaternion product q * (1, h): attitude component, h index, sign per term
	localparam logic [1:0] P_QA [4][3] = '{
		'{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3}, '{2'd0, 2'd1, 2'd2}};
	localparam logic [1:0] P_HB [4][3] = '{
		'{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd1, 2'd0}};
	localparam logic P_NEG [4][3] = '{
		'{1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1}};

	// rotation products: xx yy zz xy xz yz wx wy wz
	localparam logic [1:0] ROT_A [9] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
	localparam logic [1:0] ROT_B [9] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/imd_mul.sv
// Shared signed multiplier with registered product.
// Depends on imd_pkg for operand and product widths.
`default_nettype none

module imd_mul (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [imd_pkg::MUL_W-1:0]  a,
	input  wire logic signed [imd_pkg::MUL_W-1:0]  b,
	output logic signed [imd_pkg::PROD_W-1:0]      prod
);

	logic signed [imd_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

>>> sv/imd_rootdiv.sv
// Bit-serial unit: 64-bit integer square root, or saturating (s * 2^30) / r.
// One result bit per cycle, 32 result bits per operation. Depends on imd_pkg.
`default_nettype none

module imd_rootdiv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire imd_pkg::rd_req_t   req,
	input  wire logic [63:0]        rad,
	input  wire logic signed [31:0] num,
	input  wire logic [31:0]        den,
	output imd_pkg::rd_rsp_t        rsp
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	imd_pkg::rd_op_t op_q;

	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] quot_q;
	logic        ovf_q;
	logic        neg_q;

	logic [63:0] trial;
	logic [32:0] rem2;
	logic        ge;
	logic [31:0] mag;
	logic [31:0] hi;
	logic [31:0] div_val;

	assign trial = res_q + bit_q;
	assign rem2  = {rem_q, lo_q[31]};
	assign ge    = rem2 >= {1'b0, den};
	assign mag   = num[31] ? 32'(-num) : 32'(num);
	assign hi    = {2'b00, mag[31:2]};

	always_comb begin
		if (ovf_q) begin
			div_val = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg_q) begin
			div_val = (quot_q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-quot_q);
		end else begin
			div_val = (quot_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot_q;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = (op_q == imd_pkg::RD_ROOT) ? res_q[31:0] : div_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= imd_pkg::RD_ROOT;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q    <= rad;
			res_q  <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
			rem_q  <= hi;
			lo_q   <= {mag[1:0], 30'b0};
			quot_q <= '0;
			ovf_q  <= hi >= den;
			neg_q  <= num[31];
		end else if (busy_q) begin
			if (op_q == imd_pkg::RD_ROOT) begin
				if (n_q >= trial) begin
					n_q   <= n_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q  <= ge ? 32'(rem2 - {1'b0, den}) : rem2[31:0];
				lo_q   <= {lo_q[30:0], 1'b0};
				quot_q <= {quot_q[30:0], ge};
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/imu_midpoint_dead_reckoning_core.sv
// IMU midpoint dead-reckoning core: sequencer, state and datapath around a
// shared multiplier (imd_mul) and a bit-serial root/divide unit (imd_rootdiv).
// Depends on imd_pkg.
//
// Usage:
//   sample (valid/ready) carries one IMU word; result (valid/ready) returns
//   position and attitude for each sample. cfg (valid/ready, always ready)
//   writes gravity registers 0..2; other indexes are dropped. Write cfg only
//   while the core is idle.
//   The first sample after reset primes the stored sample and reports the
//   origin with identity attitude; its result word passes through the done
//   state into the result register.
//   Later samples run 58 products through the multiplier, each in a
//   multiply and an accumulate state, one 32-step square root and, when
//   the norm is nonzero, four 32-step divides.
//   sample_ready is high only while idle. The finished word sits in the
//   result register, so a new sample is accepted while it waits; if the
//   receiver still stalls when the next word is done, the core holds.
//   Reset clears the gravity registers and the primed flag; the next sample
//   primes again.
`default_nettype none

module imu_midpoint_dead_reckoning_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire imd_pkg::imd_sample_t sample,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output imd_pkg::imd_result_t      result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [15:0]          cfg_data
);

	localparam int AW = imd_pkg::ACC_W;
	localparam int MW = imd_pkg::MUL_W;
	localparam int PW = imd_pkg::PROD_W;
	localparam logic signed [36:0] Q_ONE_37 = 37'(imd_pkg::Q_ONE);

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_ACC, ST_ROOT, ST_DIV, ST_DONE} state_t;
	typedef enum logic [2:0] {PH_H, PH_P, PH_N, PH_RQ, PH_RA, PH_V} phase_t;

	state_t           state_q;
	phase_t           ph_q;
	logic [1:0]       maj_q;
	logic [3:0]       min_q;
	logic             pass_q;
	logic             primed_q;
	logic signed [15:0] grav_q [3];
	imd_pkg::rd_req_t rd_req_q;

	imd_pkg::imd_sample_t smp_q;
	logic [31:0]        dt_q;
	logic [31:0]        last_stamp_q;
	logic signed [15:0] last_ax_q;
	logic signed [15:0] last_ay_q;
	logic signed [15:0] last_rate_q [3];
	logic signed [31:0] att_q [4];
	logic signed [31:0] qn_q [4];
	logic signed [31:0] h_q [3];
	logic signed [31:0] s_q [4];
	logic signed [AW-1:0] acc_q;
	logic [63:0]        n2_q;
	logic [31:0]        r_q;
	logic signed [33:0] rp_q [9];
	logic signed [23:0] a0_q [3];
	logic signed [23:0] a1_q [3];
	logic signed [31:0] dv_q;
	logic signed [31:0] vel_q [3];
	logic signed [31:0] pos_q [3];

	logic               accept;
	logic signed [15:0] rate_new [3];
	logic signed [16:0] rsum;
	logic signed [31:0] rq [4];
	logic signed [36:0] rw [9];
	logic signed [MW-1:0] rm [3][2];
	logic signed [25:0] asum;
	logic signed [MW-1:0] dt_op;
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	imd_pkg::rd_rsp_t   rd_rsp;

	logic signed [PW-1:0] hs;
	logic signed [31:0]   h_val;
	logic signed [AW-1:0] tp;
	logic signed [AW-1:0] acc_p;
	logic signed [AW-1:0] p_clamp;
	logic signed [AW-1:0] acc_r;
	logic signed [AW-1:0] acc_v1;
	logic signed [AW-1:0] acc_v2;

	assign accept       = sample_valid && sample_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;

	assign rate_new[0] = smp_q.rate_x;
	assign rate_new[1] = smp_q.rate_y;
	assign rate_new[2] = smp_q.rate_z;
	assign rsum  = 17'(last_rate_q[maj_q]) + 17'(rate_new[maj_q]);
	assign dt_op = $signed({{(MW-32){1'b0}}, dt_q});

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			rq[c] = pass_q ? qn_q[c] : att_q[c];
		end
		for (int j = 0; j < 9; j++) begin
			rw[j] = 37'(rp_q[j]);
		end
		rm[0][0] = MW'(37'(Q_ONE_37) - ((rw[1] + rw[2]) <<< 1));
		rm[0][1] = MW'((rw[3] - rw[8]) <<< 1);
		rm[1][0] = MW'((rw[3] + rw[8]) <<< 1);
		rm[1][1] = MW'(37'(Q_ONE_37) - ((rw[0] + rw[2]) <<< 1));
		rm[2][0] = MW'((rw[4] - rw[7]) <<< 1);
		rm[2][1] = MW'((rw[5] + rw[6]) <<< 1);
	end

	assign asum = 26'(a0_q[maj_q]) - 26'(grav_q[maj_q]) + 26'(a1_q[maj_q])
		- 26'(grav_q[maj_q]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ph_q)
			PH_H: begin
				mul_a = MW'(rsum >>> 1);
				mul_b = dt_op;
			end
			PH_P: begin
				mul_a = MW'(att_q[imd_pkg::P_QA[maj_q][min_q[1:0]]]);
				mul_b = MW'(h_q[imd_pkg::P_HB[maj_q][min_q[1:0]]]);
			end
			PH_N: begin
				mul_a = MW'(s_q[maj_q]);
				mul_b = MW'(s_q[maj_q]);
			end
			PH_RQ: begin
				mul_a = MW'(rq[imd_pkg::ROT_A[min_q]]);
				mul_b = MW'(rq[imd_pkg::ROT_B[min_q]]);
			end
			PH_RA: begin
				mul_a = rm[maj_q][min_q[0]];
				if (min_q[0]) begin
					mul_b = MW'(pass_q ? smp_q.accel_y : last_ay_q);
				end else begin
					mul_b = MW'(pass_q ? smp_q.accel_x : last_ax_q);
				end
			end
			PH_V: begin
				mul_b = dt_op;
				case (min_q[1:0])
					2'd0:    mul_a = MW'(asum >>> 1);
					2'd1:    mul_a = MW'(vel_q[maj_q]);
					default: mul_a = MW'(dv_q);
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	imd_mul u_mul (
		.clk  (clk),
		.en   (state_q == ST_MUL),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	imd_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req_q),
		.rad    (n2_q),
		.num    (s_q[maj_q]),
		.den    (r_q),
		.rsp    (rd_rsp)
	);

	// half angle clamp to +-1 rad
	assign hs = prod >>> 3;
	always_comb begin
		if (hs > PW'(imd_pkg::Q_ONE)) begin
			h_val = imd_pkg::Q_ONE;
		end else if (hs < -PW'(imd_pkg::Q_ONE)) begin
			h_val = -imd_pkg::Q_ONE;
		end else begin
			h_val = 32'(hs);
		end
	end

	assign tp    = AW'(prod >>> 30);
	assign acc_p = ((min_q == 4'd0) ? AW'(att_q[maj_q]) : acc_q)
		+ (imd_pkg::P_NEG[maj_q][min_q[1:0]] ? -tp : tp);
	assign p_clamp = (acc_p > imd_pkg::P_LIM) ? imd_pkg::P_LIM :
		(acc_p < -imd_pkg::P_LIM) ? -imd_pkg::P_LIM : acc_p;

	assign acc_r  = (min_q[0] ? acc_q : '0) + AW'(prod);
	assign acc_v1 = AW'(pos_q[maj_q]) + AW'(prod >>> 20);
	assign acc_v2 = acc_q + AW'(prod >>> 21);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ph_q         <= PH_H;
			maj_q        <= '0;
			min_q        <= '0;
			pass_q       <= 1'b0;
			primed_q     <= 1'b0;
			grav_q       <= '{default: '0};
			rd_req_q     <= '{start: 1'b0, op: imd_pkg::RD_ROOT};
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			rd_req_q.start <= 1'b0;
			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			if (cfg_valid) begin
				case (cfg_index)
					imd_pkg::REG_GRAV_X: grav_q[0] <= cfg_data;
					imd_pkg::REG_GRAV_Y: grav_q[1] <= cfg_data;
					imd_pkg::REG_GRAV_Z: grav_q[2] <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ph_q   <= PH_H;
						maj_q  <= '0;
						min_q  <= '0;
						pass_q <= 1'b0;
						if (!primed_q) begin
							primed_q <= 1'b1;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
					case (ph_q)
						PH_H: begin
							if (maj_q == 2'd2) begin
								ph_q  <= PH_P;
								maj_q <= '0;
							end else begin
								maj_q <= maj_q + 2'd1;
							end
						end
						PH_P: begin
							if (min_q == 4'd2) begin
								min_q <= '0;
								if (maj_q == 2'd3) begin
									ph_q  <= PH_N;
									maj_q <= '0;
								end else begin
									maj_q <= maj_q + 2'd1;
								end
							end else begin
								min_q <= min_q + 4'd1;
							end
						end
						PH_N: begin
							if (maj_q == 2'd3) begin
								state_q  <= ST_ROOT;
								rd_req_q <= '{start: 1'b1, op: imd_pkg::RD_ROOT};
							end else begin
								maj_q <= maj_q + 2'd1;
							end
						end
						PH_RQ: begin
							if (min_q == 4'd8) begin
								ph_q  <= PH_RA;
								min_q <= '0;
								maj_q <= '0;
							end else begin
								min_q <= min_q + 4'd1;
							end
						end
						PH_RA: begin
							if (min_q[0]) begin
								min_q <= '0;
								if (maj_q == 2'd2) begin
									maj_q <= '0;
									if (!pass_q) begin
										pass_q <= 1'b1;
										ph_q   <= PH_RQ;
									end else begin
										ph_q <= PH_V;
									end
								end else begin
									maj_q <= maj_q + 2'd1;
								end
							end else begin
								min_q <= min_q + 4'd1;
							end
						end
						PH_V: begin
							if (min_q == 4'd2) begin
								min_q <= '0;
								if (maj_q == 2'd2) begin
									state_q <= ST_DONE;
								end else begin
									maj_q <= maj_q + 2'd1;
								end
							end else begin
								min_q <= min_q + 4'd1;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_ROOT: begin
					if (rd_rsp.done) begin
						maj_q <= '0;
						min_q <= '0;
						if (rd_rsp.value == 32'd0) begin
							ph_q    <= PH_RQ;
							state_q <= ST_MUL;
						end else begin
							state_q  <= ST_DIV;
							rd_req_q <= '{start: 1'b1, op: imd_pkg::RD_DIV};
						end
					end
				end
				ST_DIV: begin
					if (rd_rsp.done) begin
						if (maj_q == 2'd3) begin
							maj_q   <= '0;
							ph_q    <= PH_RQ;
							state_q <= ST_MUL;
						end else begin
							maj_q    <= maj_q + 2'd1;
							rd_req_q <= '{start: 1'b1, op: imd_pkg::RD_DIV};
						end
					end
				end
				ST_DONE: begin
					if (!result_valid || result_ready) begin
						result_valid <= 1'b1;
						result <= '{pos_q[0], pos_q[1], pos_q[2],
							att_q[0], att_q[1], att_q[2], att_q[3]};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
			dt_q  <= sample.stamp - last_stamp_q;
			n2_q  <= '0;
			if (!primed_q) begin
				last_stamp_q   <= sample.stamp;
				last_ax_q      <= sample.accel_x;
				last_ay_q      <= sample.accel_y;
				last_rate_q[0] <= sample.rate_x;
				last_rate_q[1] <= sample.rate_y;
				last_rate_q[2] <= sample.rate_z;
				att_q <= '{imd_pkg::Q_ONE, 32'sd0, 32'sd0, 32'sd0};
				vel_q <= '{default: '0};
				pos_q <= '{default: '0};
			end
		end
		if (state_q == ST_ROOT && rd_rsp.done) begin
			r_q <= rd_rsp.value;
			if (rd_rsp.value == 32'd0) begin
				qn_q <= '{imd_pkg::Q_ONE, 32'sd0, 32'sd0, 32'sd0};
			end
		end
		if (state_q == ST_DIV && rd_rsp.done) begin
			qn_q[maj_q] <= rd_rsp.value;
		end
		if (state_q == ST_ACC) begin
			case (ph_q)
				PH_H: h_q[maj_q] <= h_val;
				PH_P: begin
					acc_q <= acc_p;
					if (min_q == 4'd2) begin
						s_q[maj_q] <= 32'(p_clamp >>> 2);
					end
				end
				PH_N: n2_q <= n2_q + prod[63:0];
				PH_RQ: rp_q[min_q] <= 34'(prod >>> 30);
				PH_RA: begin
					acc_q <= acc_r;
					if (min_q[0]) begin
						if (pass_q) begin
							a1_q[maj_q] <= 24'(acc_r >>> 30);
						end else begin
							a0_q[maj_q] <= 24'(acc_r >>> 30);
						end
					end
				end
				PH_V: begin
					case (min_q[1:0])
						2'd0: dv_q <= imd_pkg::sat32(64'(prod >>> 12));
						2'd1: acc_q <= acc_v1;
						default: begin
							pos_q[maj_q] <= imd_pkg::sat32(64'(acc_v2));
							vel_q[maj_q] <= imd_pkg::sat32(64'(vel_q[maj_q]) + 64'(dv_q));
							last_rate_q[maj_q] <= rate_new[maj_q];
							if (maj_q == 2'd2) begin
								att_q        <= qn_q;
								last_ax_q    <= smp_q.accel_x;
								last_ay_q    <= smp_q.accel_y;
								last_stamp_q <= smp_q.stamp;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	a_rd_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rd_rsp.done |-> (state_q == ST_ROOT || state_q == ST_DIV))
		else $error("root/divide result outside a wait state");

	a_prime_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !primed_q) |=> (state_q == ST_DONE && primed_q))
		else $error("priming word did not go straight to done");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && result_valid && !result_ready) |=> (state_q == ST_DONE))
		else $error("finished word overwrote a pending result");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking bench for imu_midpoint_dead_reckoning_core: random and directed IMU
// words go in, predicted position/attitude words are compared as results come out.
// Depends on imd_pkg and the core RTL.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint QONE = 64'sd1 << 30;
	localparam longint PLIM = (64'sd1 << 33) - 1;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 600;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	imd_pkg::imd_sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	imd_pkg::imd_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = imd_pkg::REG_GRAV_X;
	logic [15:0] cfg_data = '0;

	imu_midpoint_dead_reckoning_core dut (.*);

	// stimulus and expectations
	imd_pkg::imd_sample_t pending_words[$];
	imd_pkg::imd_result_t expected_nav[$];
	int idle_mode = 0;
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int rx_stall_left = 0;
	int watchdog = 0;
	logic [31:0] next_stamp = 32'd1000;

	// predictor state
	logic [15:0] grav_reg[3];
	bit nav_primed;
	logic [31:0] prev_stamp;
	longint prev_accel[2];
	longint prev_rate[3];
	longint att[4];
	longint vel[3];
	longint pos[3];

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint clamp64(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sat_s32(longint v);
		return clamp64(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic void body_to_world(input longint q[4], input longint ax,
			input longint ay, output longint o[3]);
		longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
		longint r00, r01, r10, r11, r20, r21;
		xx = qmul(q[1], q[1]); yy = qmul(q[2], q[2]); zz = qmul(q[3], q[3]);
		xy = qmul(q[1], q[2]); xz = qmul(q[1], q[3]); yz = qmul(q[2], q[3]);
		wx = qmul(q[0], q[1]); wy = qmul(q[0], q[2]); wz = qmul(q[0], q[3]);
		r00 = QONE - 2 * (yy + zz); r01 = 2 * (xy - wz);
		r10 = 2 * (xy + wz);        r11 = QONE - 2 * (xx + zz);
		r20 = 2 * (xz - wy);        r21 = 2 * (yz + wx);
		o[0] = (r00 * ax + r01 * ay) >>> 30;
		o[1] = (r10 * ax + r11 * ay) >>> 30;
		o[2] = (r20 * ax + r21 * ay) >>> 30;
	endfunction

	function automatic imd_pkg::imd_result_t pack_nav();
		imd_pkg::imd_result_t r;
		r.pos_x = pos[0][31:0]; r.pos_y = pos[1][31:0]; r.pos_z = pos[2][31:0];
		r.quat_w = att[0][31:0]; r.quat_x = att[1][31:0];
		r.quat_y = att[2][31:0]; r.quat_z = att[3][31:0];
		return r;
	endfunction

	function automatic imd_pkg::imd_result_t integrate_sample(imd_pkg::imd_sample_t smp);
		longint rt[3], h[3], p[4], s[4], a0[3], a1[3], qn[4];
		longint ax, ay, dt, m, g, a, dv, dp;
		longint unsigned n2, root;
		logic [31:0] dstamp;
		ax = smp.accel_x; ay = smp.accel_y;
		rt[0] = smp.rate_x; rt[1] = smp.rate_y; rt[2] = smp.rate_z;
		if (!nav_primed) begin
			for (int k = 0; k < 3; k++) begin
				prev_rate[k] = rt[k]; vel[k] = 0; pos[k] = 0;
			end
			prev_accel[0] = ax; prev_accel[1] = ay;
			prev_stamp = smp.stamp;
			att[0] = QONE; att[1] = 0; att[2] = 0; att[3] = 0;
			nav_primed = 1'b1;
			return pack_nav();
		end
		dstamp = smp.stamp - prev_stamp;
		dt = {32'd0, dstamp};
		for (int k = 0; k < 3; k++) begin
			m = (prev_rate[k] + rt[k]) >>> 1;
			h[k] = clamp64((m * dt) >>> 3, -QONE, QONE);
		end
		p[0] = att[0] - qmul(att[1], h[0]) - qmul(att[2], h[1]) - qmul(att[3], h[2]);
		p[1] = qmul(att[0], h[0]) + att[1] + qmul(att[2], h[2]) - qmul(att[3], h[1]);
		p[2] = qmul(att[0], h[1]) - qmul(att[1], h[2]) + att[2] + qmul(att[3], h[0]);
		p[3] = qmul(att[0], h[2]) + qmul(att[1], h[1]) - qmul(att[2], h[0]) + att[3];
		n2 = 0;
		for (int k = 0; k < 4; k++) begin
			s[k] = clamp64(p[k], -PLIM, PLIM) >>> 2;
			n2 += longint'(s[k] * s[k]);
		end
		root = int_sqrt(n2);
		if (root == 0) begin
			qn[0] = QONE; qn[1] = 0; qn[2] = 0; qn[3] = 0;
		end else begin
			for (int k = 0; k < 4; k++) qn[k] = sat_s32((s[k] * QONE) / longint'(root));
		end
		body_to_world(att, prev_accel[0], prev_accel[1], a0);
		body_to_world(qn, ax, ay, a1);
		for (int k = 0; k < 3; k++) begin
			g = $signed(grav_reg[k]);
			a = (a0[k] - g + a1[k] - g) >>> 1;
			dv = sat_s32((a * dt) >>> 12);
			dp = ((vel[k] * dt) >>> 20) + ((dv * dt) >>> 21);
			pos[k] = sat_s32(pos[k] + dp);
			vel[k] = sat_s32(vel[k] + dv);
			prev_rate[k] = rt[k];
		end
		for (int k = 0; k < 4; k++) att[k] = qn[k];
		prev_accel[0] = ax; prev_accel[1] = ay;
		prev_stamp = smp.stamp;
		return pack_nav();
	endfunction

	// driver
	always @(posedge clk) begin
		bit accepted;
		bit gap;
		accepted = sample_valid && sample_ready;
		if (accepted) begin
			expected_nav = {expected_nav, integrate_sample(sample)};
			words_in++;
		end
		case (idle_mode)
			0: gap = $urandom_range(0, 99) < 14;
			1: gap = $urandom_range(0, 99) < 80;
			default: gap = 1'b0;
		endcase
		if (!sample_valid || accepted) begin
			if (pending_words.size() > 0 && !gap) begin
				sample <= pending_words.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bit stall;
		imd_pkg::imd_result_t want;
		string fname[7];
		fname = '{"pos_x", "pos_y", "pos_z", "quat_w", "quat_x", "quat_y", "quat_z"};
		if (result_valid && result_ready) begin
			words_out++;
			if (expected_nav.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", result);
			end else begin
				want = expected_nav.pop_front();
				for (int k = 0; k < 7; k++) begin
					if (result[223 - 32 * k -: 32] !== want[223 - 32 * k -: 32]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d %s: expected %h got %h", words_out, fname[k],
								want[223 - 32 * k -: 32], result[223 - 32 * k -: 32]);
					end
				end
			end
			if (words_out == 150 || words_out == 900) rx_stall_left = 3000;
		end
		if (rx_stall_left > 0) rx_stall_left--;
		case (idle_mode)
			0: stall = $urandom_range(0, 99) < 80;
			1: stall = $urandom_range(0, 99) < 14;
			default: stall = 1'b0;
		endcase
		result_ready <= (rx_stall_left == 0) && !stall;
	end

	// watchdog
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready) || !arst_n) begin
			watchdog <= 0;
		end else if (watchdog >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			watchdog <= watchdog + 1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx <= imd_pkg::REG_GRAV_Z) grav_reg[idx] = val;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick16(bit narrow);
		return narrow ? 16'($signed($urandom_range(0, 1023)) - 512) : 16'($urandom);
	endfunction

	task automatic add_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] rx,
			logic [15:0] ry, logic [15:0] rz, logic [31:0] st);
		imd_pkg::imd_sample_t w;
		w.accel_x = ax; w.accel_y = ay;
		w.rate_x = rx; w.rate_y = ry; w.rate_z = rz;
		w.stamp = st;
		pending_words = {pending_words, w};
	endtask

	task automatic add_random_word();
		int sel;
		bit narrow;
		sel = $urandom_range(0, 99);
		narrow = $urandom_range(0, 99) < 70;
		if (sel < 90) next_stamp += $urandom_range(0, 4000);
		else if (sel < 95) next_stamp = $urandom;
		else next_stamp -= $urandom_range(1, 5000);
		add_word(pick16(narrow), pick16(narrow), pick16(narrow), pick16(narrow),
			pick16(narrow), next_stamp);
	endtask

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !sample_valid && expected_nav.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] gx[6], gy[6], gz[6];
		gx = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000};
		gy = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
		gz = '{16'h0000, 16'h7FFF, 16'h8000, 16'h09CF, 16'h0000, 16'h0000};
		gx[4] = 16'($urandom); gy[4] = 16'($urandom); gz[4] = 16'($urandom);
		for (int k = 0; k < 3; k++) grav_reg[k] = '0;
		nav_primed = 1'b0;
		prev_stamp = '0;
		prev_accel = '{0, 0};
		prev_rate = '{0, 0, 0};
		att = '{QONE, 0, 0, 0};
		vel = '{0, 0, 0};
		pos = '{0, 0, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: priming, zero dt, extremes, wrap, stamp going back, big rotation
		add_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 32'hFFFF_F000);
		add_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 32'hFFFF_F000);
		add_word(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 32'h0000_0400);
		add_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 32'h0000_0800);
		add_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h0010_0800);
		add_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8010_0800);
		add_word(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		add_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
		add_word(16'h0080, 16'hFF80, 16'h0400, 16'hFC00, 16'h0200, 32'h0000_1000);
		add_word(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
		add_word(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFFE);
		add_word(16'h0100, 16'h0100, 16'h0010, 16'h0010, 16'h0010, 32'h0000_0010);
		wait_idle();
		for (int phase = 0; phase < 6; phase++) begin
			idle_mode = phase / 2;
			write_reg(imd_pkg::REG_GRAV_X, gx[phase]);
			write_reg(imd_pkg::REG_GRAV_Y, gy[phase]);
			write_reg(imd_pkg::REG_GRAV_Z, gz[phase]);
			write_reg(REG_UNUSED, 16'($urandom));
			for (int i = 0; i < 228; i++) add_random_word();
			wait_idle();
		end
		$display("%0d samples in, %0d results out, 6 gravity settings, sender/receiver stalls",
			words_in, words_out);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> imu_midpoint_dead_reckoning_core.f
sv/imd_pkg.sv
sv/imd_mul.sv
sv/imd_rootdiv.sv
sv/imu_midpoint_dead_reckoning_core.sv
dv/testbench.sv
